// ===== rtl/core/binomial_exact_division_defines.svh =====
// assertion macros for the binomial exact division block
`ifndef BINOMIAL_EXACT_DIVISION_DEFINES_SVH
`define BINOMIAL_EXACT_DIVISION_DEFINES_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define BED_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while reset is asserted
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// ===== rtl/core/bed_pkg.sv =====
// types, constants and lookup tables shared by the binomial exact division block
`default_nettype none
package bed_pkg;

	localparam int NW = 31;
	localparam int KW = 7;
	localparam int CW = 64;
	localparam int HW = 32;
	localparam int SHW = 3;
	localparam logic [KW-1:0] MAX_K = 7'd64;
	localparam logic [KW-1:0] FIRST_Z = 7'd2;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_INIT,
		OP_M1_LO,
		OP_M1_HI,
		OP_M1_ADD,
		OP_M2_LL,
		OP_M2_LH,
		OP_M2_HL,
		OP_M2_ADD
	} dp_op_t;

	typedef struct packed {
		logic run_loop;
		logic last_step;
	} dp_status_t;

	// exponent of two in z, z from 1 to 64
	function automatic logic [SHW-1:0] two_exp(input logic [KW-1:0] z);
		logic [SHW-1:0] e;
		priority if (z[0]) e = 3'd0;
		else if (z[1]) e = 3'd1;
		else if (z[2]) e = 3'd2;
		else if (z[3]) e = 3'd3;
		else if (z[4]) e = 3'd4;
		else if (z[5]) e = 3'd5;
		else e = 3'd6;
		return e;
	endfunction

	// inverse modulo 2^64 of the odd part of z
	function automatic logic [CW-1:0] odd_inv(input logic [KW-1:0] z);
		logic [CW-1:0] v;
		unique case (z)
			7'd0: v = 64'h0;
			7'd1: v = 64'h1;
			7'd2: v = 64'h1;
			7'd3: v = 64'haaaaaaaaaaaaaaab;
			7'd4: v = 64'h1;
			7'd5: v = 64'hcccccccccccccccd;
			7'd6: v = 64'haaaaaaaaaaaaaaab;
			7'd7: v = 64'h6db6db6db6db6db7;
			7'd8: v = 64'h1;
			7'd9: v = 64'h8e38e38e38e38e39;
			7'd10: v = 64'hcccccccccccccccd;
			7'd11: v = 64'h2e8ba2e8ba2e8ba3;
			7'd12: v = 64'haaaaaaaaaaaaaaab;
			7'd13: v = 64'h4ec4ec4ec4ec4ec5;
			7'd14: v = 64'h6db6db6db6db6db7;
			7'd15: v = 64'heeeeeeeeeeeeeeef;
			7'd16: v = 64'h1;
			7'd17: v = 64'hf0f0f0f0f0f0f0f1;
			7'd18: v = 64'h8e38e38e38e38e39;
			7'd19: v = 64'h86bca1af286bca1b;
			7'd20: v = 64'hcccccccccccccccd;
			7'd21: v = 64'hcf3cf3cf3cf3cf3d;
			7'd22: v = 64'h2e8ba2e8ba2e8ba3;
			7'd23: v = 64'hd37a6f4de9bd37a7;
			7'd24: v = 64'haaaaaaaaaaaaaaab;
			7'd25: v = 64'h8f5c28f5c28f5c29;
			7'd26: v = 64'h4ec4ec4ec4ec4ec5;
			7'd27: v = 64'h84bda12f684bda13;
			7'd28: v = 64'h6db6db6db6db6db7;
			7'd29: v = 64'h34f72c234f72c235;
			7'd30: v = 64'heeeeeeeeeeeeeeef;
			7'd31: v = 64'hef7bdef7bdef7bdf;
			7'd32: v = 64'h1;
			7'd33: v = 64'h0f83e0f83e0f83e1;
			7'd34: v = 64'hf0f0f0f0f0f0f0f1;
			7'd35: v = 64'haf8af8af8af8af8b;
			7'd36: v = 64'h8e38e38e38e38e39;
			7'd37: v = 64'h14c1bacf914c1bad;
			7'd38: v = 64'h86bca1af286bca1b;
			7'd39: v = 64'h6f96f96f96f96f97;
			7'd40: v = 64'hcccccccccccccccd;
			7'd41: v = 64'h8f9c18f9c18f9c19;
			7'd42: v = 64'hcf3cf3cf3cf3cf3d;
			7'd43: v = 64'h82fa0be82fa0be83;
			7'd44: v = 64'h2e8ba2e8ba2e8ba3;
			7'd45: v = 64'h4fa4fa4fa4fa4fa5;
			7'd46: v = 64'hd37a6f4de9bd37a7;
			7'd47: v = 64'h51b3bea3677d46cf;
			7'd48: v = 64'haaaaaaaaaaaaaaab;
			7'd49: v = 64'h7d6343eb1a1f58d1;
			7'd50: v = 64'h8f5c28f5c28f5c29;
			7'd51: v = 64'hfafafafafafafafb;
			7'd52: v = 64'h4ec4ec4ec4ec4ec5;
			7'd53: v = 64'h21cfb2b78c13521d;
			7'd54: v = 64'h84bda12f684bda13;
			7'd55: v = 64'h6fb586fb586fb587;
			7'd56: v = 64'h6db6db6db6db6db7;
			7'd57: v = 64'h823ee08fb823ee09;
			7'd58: v = 64'h34f72c234f72c235;
			7'd59: v = 64'hcbeea4e1a08ad8f3;
			7'd60: v = 64'heeeeeeeeeeeeeeef;
			7'd61: v = 64'h4fbcda3ac10c9715;
			7'd62: v = 64'hef7bdef7bdef7bdf;
			7'd63: v = 64'hefbefbefbefbefbf;
			7'd64: v = 64'h1;
			default: v = 64'h0;
		endcase
		return v;
	endfunction

	// largest n for which no intermediate product wraps
	function automatic logic [NW-1:0] safe_top(input logic [KW-1:0] k);
		logic [NW-1:0] v;
		unique case (k)
			7'd0: v = 31'd0;
			7'd1: v = 31'd2147483647;
			7'd2: v = 31'd2642246;
			7'd3: v = 31'd77936;
			7'd4: v = 31'd10206;
			7'd5: v = 31'd2762;
			7'd6: v = 31'd1122;
			7'd7: v = 31'd585;
			7'd8: v = 31'd359;
			7'd9: v = 31'd247;
			7'd10: v = 31'd184;
			7'd11: v = 31'd146;
			7'd12: v = 31'd121;
			7'd13: v = 31'd104;
			7'd14: v = 31'd92;
			7'd15: v = 31'd83;
			7'd16: v = 31'd77;
			7'd17: v = 31'd72;
			7'd18: v = 31'd68;
			7'd19: v = 31'd65;
			7'd20: v = 31'd63;
			7'd21: v = 31'd61;
			7'd22: v = 31'd59;
			7'd23, 7'd24: v = 31'd58;
			7'd25, 7'd26: v = 31'd57;
			7'd27, 7'd28, 7'd29, 7'd30, 7'd31: v = 31'd56;
			7'd32, 7'd33, 7'd34: v = 31'd57;
			7'd35, 7'd36, 7'd37: v = 31'd58;
			7'd38, 7'd39: v = 31'd59;
			7'd40: v = 31'd60;
			7'd41, 7'd42: v = 31'd61;
			default: v = 31'd62;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/binomial_exact_division.sv =====
// an item goes through load and init and then to the result strobe when no loop runs
// (k of 0, 1 or above 64, or n below k), else k-1 loop steps come before it
// one item at a time: a new item is taken only after the strobe, back in idle;
// each loop step issues five partial products on the shared 32x32 multiplier and has two
// more steps that accumulate and shift
// reset: asynchronous, returns the controller to idle; the receiver cannot stall
`default_nettype none
`include "binomial_exact_division_defines.svh"
module binomial_exact_division (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [bed_pkg::NW-1:0]  top_count,
	input  wire logic [bed_pkg::KW-1:0]  choose_count,
	output logic                         done,
	output logic [bed_pkg::CW-1:0]       coefficient,
	output logic                         unsafe
);
	import bed_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	bed_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	bed_datapath u_datapath (
		.clk          (clk),
		.top_count    (top_count),
		.choose_count (choose_count),
		.op           (op),
		.status       (status),
		.coefficient  (coefficient),
		.unsafe       (unsafe)
	);

	`BED_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy,
		"accepted beat did not raise busy")
	`BED_ASSERT_NEXT(a_done_frees, done, !busy && !done,
		"result strobe not followed by idle")
	`BED_ASSERT_SAME(a_zero_choose, start && !busy && choose_count == '0,
		##2 (done && coefficient == 64'd1 && !unsafe),
		"zero choose count result wrong")
	`BED_ASSERT_SAME(a_big_choose, start && !busy && choose_count > MAX_K,
		##2 (done && coefficient == 64'd0 && unsafe),
		"oversized choose count result wrong")

endmodule
`default_nettype wire

// ===== rtl/core/bed_datapath.sv =====
// datapath: operand registers, shared 32x32 multiplier, accumulators and tables
`default_nettype none
module bed_datapath (
	input  wire logic                    clk,
	input  wire logic [bed_pkg::NW-1:0]  top_count,
	input  wire logic [bed_pkg::KW-1:0]  choose_count,
	input  wire bed_pkg::dp_op_t         op,
	output bed_pkg::dp_status_t          status,
	output logic [bed_pkg::CW-1:0]       coefficient,
	output logic                         unsafe
);
	import bed_pkg::*;

	logic [NW-1:0]  n_q;
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  z_q;
	logic [HW-1:0]  m_q;
	logic [CW-1:0]  acc_q;
	logic [CW-1:0]  tmp_q;
	logic [CW-1:0]  inv_q;
	logic [SHW-1:0] sh_q;
	logic [CW-1:0]  prod_q;
	logic           flag_q;

	logic [NW-1:0]  d;
	logic           k_big;
	logic           k_zero;
	logic           n_small;
	logic [CW-1:0]  init_acc;
	logic           init_flag;
	logic [HW-1:0]  mul_a;
	logic [HW-1:0]  mul_b;
	logic [CW-1:0]  acc_sum;
	logic [CW-1:0]  tmp_sum;

	assign d       = n_q - {{(NW-KW){1'b0}}, k_q};
	assign k_big   = k_q > MAX_K;
	assign k_zero  = k_q == '0;
	assign n_small = n_q < {{(NW-KW){1'b0}}, k_q};

	always_comb begin
		init_acc  = '0;
		init_flag = 1'b0;
		priority if (k_big) begin
			init_flag = 1'b1;
		end else if (k_zero) begin
			init_acc = {{(CW-1){1'b0}}, 1'b1};
		end else if (n_small) begin
			init_acc = '0;
		end else begin
			init_acc  = {{(CW-NW){1'b0}}, d} + {{(CW-1){1'b0}}, 1'b1};
			init_flag = n_q > safe_top(k_q);
		end
	end

	assign status.run_loop  = !k_big && !n_small && (k_q >= FIRST_Z);
	assign status.last_step = z_q == k_q;

	// operand select for the shared multiplier, one partial product a cycle
	always_comb begin
		unique case (op)
			OP_M1_LO: begin
				mul_a = acc_q[HW-1:0];
				mul_b = m_q;
			end
			OP_M1_HI: begin
				mul_a = acc_q[CW-1:HW];
				mul_b = m_q;
			end
			OP_M2_LL: begin
				mul_a = tmp_q[HW-1:0];
				mul_b = inv_q[HW-1:0];
			end
			OP_M2_LH: begin
				mul_a = tmp_q[HW-1:0];
				mul_b = inv_q[CW-1:HW];
			end
			OP_M2_HL: begin
				mul_a = tmp_q[CW-1:HW];
				mul_b = inv_q[HW-1:0];
			end
			default: begin
				mul_a = acc_q[HW-1:0];
				mul_b = m_q;
			end
		endcase
	end

	assign acc_sum = acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
	assign tmp_sum = tmp_q + {prod_q[HW-1:0], {HW{1'b0}}};

	always_ff @(posedge clk) begin
		prod_q <= {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};
		unique case (op)
			OP_LOAD: begin
				n_q <= top_count;
				k_q <= choose_count;
			end
			OP_INIT: begin
				acc_q  <= init_acc;
				flag_q <= init_flag;
				m_q    <= {1'b0, d} + {{(HW-2){1'b0}}, 2'd2};
				z_q    <= FIRST_Z;
			end
			OP_M1_LO: begin
				inv_q <= odd_inv(z_q);
				sh_q  <= two_exp(z_q);
			end
			OP_M1_HI: begin
				tmp_q <= prod_q;
			end
			OP_M1_ADD: begin
				// finish acc*(d+z), then drop the power of two of z
				tmp_q <= tmp_sum >> sh_q;
			end
			OP_M2_LH: begin
				acc_q <= prod_q;
			end
			OP_M2_HL: begin
				acc_q <= acc_sum;
			end
			OP_M2_ADD: begin
				acc_q <= acc_sum;
				z_q   <= z_q + {{(KW-1){1'b0}}, 1'b1};
				m_q   <= m_q + {{(HW-1){1'b0}}, 1'b1};
			end
			default: begin
			end
		endcase
	end

	assign coefficient = acc_q;
	assign unsafe      = flag_q;

endmodule
`default_nettype wire

// ===== rtl/core/bed_ctrl.sv =====
// controller: sequences one item through the load, init and loop steps
`default_nettype none
module bed_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire bed_pkg::dp_status_t status,
	output bed_pkg::dp_op_t         op,
	output logic                    busy,
	output logic                    done
);
	import bed_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_INIT   = 10'b00_0000_0010,
		S_M1_LO  = 10'b00_0000_0100,
		S_M1_HI  = 10'b00_0000_1000,
		S_M1_ADD = 10'b00_0001_0000,
		S_M2_LL  = 10'b00_0010_0000,
		S_M2_LH  = 10'b00_0100_0000,
		S_M2_HL  = 10'b00_1000_0000,
		S_M2_ADD = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				state_d = start ? S_INIT : S_IDLE;
				op      = start ? OP_LOAD : OP_IDLE;
			end
			S_INIT: begin
				state_d = status.run_loop ? S_M1_LO : S_DONE;
				op      = OP_INIT;
			end
			S_M1_LO: begin
				state_d = S_M1_HI;
				op      = OP_M1_LO;
			end
			S_M1_HI: begin
				state_d = S_M1_ADD;
				op      = OP_M1_HI;
			end
			S_M1_ADD: begin
				state_d = S_M2_LL;
				op      = OP_M1_ADD;
			end
			S_M2_LL: begin
				state_d = S_M2_LH;
				op      = OP_M2_LL;
			end
			S_M2_LH: begin
				state_d = S_M2_HL;
				op      = OP_M2_LH;
			end
			S_M2_HL: begin
				state_d = S_M2_ADD;
				op      = OP_M2_HL;
			end
			S_M2_ADD: begin
				state_d = status.last_step ? S_DONE : S_M1_LO;
				op      = OP_M2_ADD;
			end
			S_DONE: begin
				state_d = S_IDLE;
				op      = OP_IDLE;
			end
			default: begin
				state_d = S_IDLE;
				op      = OP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the binomial exact division block
`timescale 1ns / 1ps
module testbench;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 12;
	localparam int MAX_IDLE = 13;
	localparam int RANDOM_ITEMS = 1200;
	localparam int TAIL_CYCLES = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [bed_pkg::CW-1:0] coefficient;
		logic                   unsafe;
		logic [bed_pkg::NW-1:0] n;
		logic [bed_pkg::KW-1:0] k;
	} coeff_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [bed_pkg::NW-1:0] top_count;
	logic [bed_pkg::KW-1:0] choose_count;
	logic                   done;
	logic [bed_pkg::CW-1:0] coefficient;
	logic                   unsafe;

	coeff_beat_t pending_coeffs[$];
	coeff_beat_t oldest;
	int          mismatches;
	longint      cycle_count;
	bit          idle_on;

	binomial_exact_division dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.top_count    (top_count),
		.choose_count (choose_count),
		.done         (done),
		.coefficient  (coefficient),
		.unsafe       (unsafe)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// largest n for which the running product stays below 2^64
	function automatic int unsigned safe_top_limit(input int k);
		case (k)
			0: return 0;
			1: return 32'd2147483647;
			2: return 2642246;
			3: return 77936;
			4: return 10206;
			5: return 2762;
			6: return 1122;
			7: return 585;
			8: return 359;
			9: return 247;
			10: return 184;
			11: return 146;
			12: return 121;
			13: return 104;
			14: return 92;
			15: return 83;
			16: return 77;
			17: return 72;
			18: return 68;
			19: return 65;
			20: return 63;
			21: return 61;
			22: return 59;
			23, 24: return 58;
			25, 26: return 57;
			27, 28, 29, 30, 31: return 56;
			32, 33, 34: return 57;
			35, 36, 37: return 58;
			38, 39: return 59;
			40: return 60;
			41, 42: return 61;
			default: return 62;
		endcase
	endfunction

	function automatic coeff_beat_t binomial_mod64(input logic [bed_pkg::NW-1:0] n,
			input logic [bed_pkg::KW-1:0] k);
		coeff_beat_t r;
		logic [63:0] acc;
		logic [63:0] d;
		logic [63:0] odd_part;
		logic [63:0] inv;
		int          z;
		int          sh;
		r.n = n;
		r.k = k;
		r.coefficient = '0;
		r.unsafe = 1'b0;
		if (k > bed_pkg::MAX_K) begin
			r.unsafe = 1'b1;
			return r;
		end
		if (k == 0) begin
			r.coefficient = 64'd1;
			return r;
		end
		if (n < 31'(k))
			return r;
		r.unsafe = (32'(n) > safe_top_limit(int'(k)));
		d = 64'(n) - 64'(k);
		acc = d + 64'd1;
		for (z = 2; z <= int'(k); z++) begin
			acc = acc * (d + 64'(z));
			odd_part = 64'(z);
			sh = 0;
			while (!odd_part[0]) begin
				odd_part = odd_part >> 1;
				sh++;
			end
			// newton steps double the correct low bits: 3, 6, 12, 24, 48, 96
			inv = odd_part;
			repeat (5) inv = inv * (64'd2 - odd_part * inv);
			acc = (acc >> sh) * inv;
		end
		r.coefficient = acc;
		return r;
	endfunction

	// entered and left just after a falling edge
	task automatic send_item(input logic [bed_pkg::NW-1:0] n, input logic [bed_pkg::KW-1:0] k);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		top_count = n;
		choose_count = k;
		do @(posedge clk); while (busy);
		pending_coeffs.push_back(binomial_mod64(n, k));
		@(negedge clk);
	endtask

	task automatic wait_all_done();
		start = 1'b0;
		while (pending_coeffs.size() != 0) @(negedge clk);
	endtask

	task automatic test_zero_choose();
		send_item('0, '0);
		send_item(31'h7fffffff, '0);
		send_item(31'd12345, '0);
	endtask

	task automatic test_choose_above_top();
		send_item('0, 7'd1);
		send_item(31'd5, 7'd10);
		send_item(31'd63, 7'd64);
	endtask

	task automatic test_choose_above_max();
		send_item(31'd100, 7'd65);
		send_item(31'h7fffffff, 7'd127);
		send_item('0, 7'd127);
	endtask

	task automatic test_safe_limits();
		send_item(31'h7fffffff, 7'd1);
		send_item(31'd2642246, 7'd2);
		send_item(31'd2642247, 7'd2);
		send_item(31'd77936, 7'd3);
		send_item(31'd77937, 7'd3);
		send_item(31'd10206, 7'd4);
		send_item(31'd10207, 7'd4);
		send_item(31'd62, 7'd62);
		send_item(31'd64, 7'd64);
		send_item(31'd127, 7'd64);
		send_item(31'h7fffffff, 7'd64);
		send_item(31'h7fffffff, 7'd2);
		wait_all_done();
	endtask

	task automatic test_random(input int count);
		int i;
		int sel;
		int k;
		int n;
		for (i = 0; i < count; i++) begin
			// alternate stretches with and without sender gaps
			if (i % 150 == 0)
				idle_on = !idle_on;
			// hold off until the block has drained
			if (i % 400 == 399)
				wait_all_done();
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				k = (sel < 20) ? $urandom_range(0, 16) : $urandom_range(0, 64);
				n = k + $urandom_range(0, 80);
			end else if (sel < 55) begin
				k = $urandom_range(2, 30);
				n = int'(safe_top_limit(k)) + $urandom_range(0, 4) - 2;
				if (n < k)
					n = k;
			end else if (sel < 75) begin
				k = $urandom_range(0, 64);
				n = $urandom() & 32'h7fffffff;
			end else if (sel < 85) begin
				k = $urandom_range(0, 127);
				n = $urandom() & 32'h7fffffff;
			end else if (sel < 95) begin
				k = $urandom_range(1, 64);
				n = $urandom_range(0, k - 1);
			end else begin
				k = $urandom_range(0, 1);
				n = $urandom() & 32'h7fffffff;
			end
			send_item(n[bed_pkg::NW-1:0], k[bed_pkg::KW-1:0]);
		end
	endtask

	// each result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_coeffs.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with none expected, actual coefficient %h unsafe %b",
					$time, coefficient, unsafe);
			end else begin
				oldest = pending_coeffs.pop_front();
				if (coefficient !== oldest.coefficient) begin
					mismatches++;
					$display("%0t: n %0d k %0d coefficient expected %h actual %h",
						$time, oldest.n, oldest.k, oldest.coefficient, coefficient);
				end
				if (unsafe !== oldest.unsafe) begin
					mismatches++;
					$display("%0t: n %0d k %0d unsafe expected %b actual %b",
						$time, oldest.n, oldest.k, oldest.unsafe, unsafe);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL binomial_exact_division");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycle_count = 0;
		idle_on = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		top_count = '0;
		choose_count = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		idle_on = 1'b1;
		test_zero_choose();
		test_choose_above_top();
		test_choose_above_max();
		test_safe_limits();
		idle_on = 1'b0;
		test_random(RANDOM_ITEMS);
		wait_all_done();
		if (pending_coeffs.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected beats never arrived", $time, pending_coeffs.size());
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASS binomial_exact_division");
		end else begin
			$display("FAIL binomial_exact_division");
		end
		$finish;
	end

endmodule
